>>> hdl/rsgt_pkg.sv
// Shared types and constants for the receive sequence gap tracker.
// Used by the interfaces, the tracking stage, the result stage and the top level.
package rsgt_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned MaxPlaceholders = 8;

  localparam logic [7:0] DupGap = 8'hFF;

  localparam int unsigned CountW = 32;
  localparam int unsigned NodeW = 16;
  localparam int unsigned SeqW = 8;
  localparam int unsigned SlotW = 4;
  localparam int unsigned DataW = 16;

  // Configuration register indexes.
  typedef enum logic {
    CFG_LOCAL_NODE_ID = 1'b0,
    CFG_CONCEAL_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_PACKET  = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KIND_LOSS    = 3'd0,
    KIND_QUEUED  = 3'd1,
    KIND_DUP     = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_OWN     = 3'd4,
    KIND_RESTART = 3'd5
  } kind_e;

  // One evaluated item as handed from the tracking stage to the result stage.
  typedef struct packed {
    kind_e             kind;
    logic [SlotW-1:0]  loss_cnt;
    logic [CountW-1:0] packets;
    logic [CountW-1:0] lost;
    logic [CountW-1:0] dropped;
  } rec_t;

endpackage

>>> hdl/rsgt_if.sv
// Valid/ready channel interfaces for header items and result items.
// Depends on rsgt_pkg for field widths.
interface rsgt_in_if;
  import rsgt_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [NodeW-1:0] sender_id;
  logic [SeqW-1:0]  sequence_req;
  logic [SlotW-1:0] queue_free;

  modport source (output valid, operation, sender_id, sequence_req, queue_free,
                  input ready);
  modport sink (input valid, operation, sender_id, sequence_req, queue_free,
                output ready);
endinterface

interface rsgt_out_if;
  import rsgt_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic              last;
  logic [CountW-1:0] packets_count;
  logic [CountW-1:0] lost_count;
  logic [CountW-1:0] dropped_count;

  modport source (output valid, kind, last, packets_count, lost_count, dropped_count,
                  input ready);
  modport sink (input valid, kind, last, packets_count, lost_count, dropped_count,
                output ready);
endinterface

>>> hdl/rx_sequence_gap_tracker_top.sv
// Receive sequence gap tracker, top level. A header is registered in the input
// register, evaluated combinationally against the sequence state and loaded
// into the result register. An item with n loss placeholders puts them out
// ahead of its final result, and the next header is taken in the cycle its
// final result leaves, so single-result items flow one per cycle while the
// output is ready. Reset (rst_ni, async low) clears tracking state, counters
// and sets the conceal limit to 2 and the local node id to 0.
module rx_sequence_gap_tracker_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rsgt_pkg::DataW-1:0] cfg_wdata_i,
  rsgt_in_if.sink                    in_if,
  rsgt_out_if.source                 out_if
);
  import rsgt_pkg::*;

  logic rec_valid;
  logic rec_take;
  rec_t rec;

  rsgt_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .rec_valid_o (rec_valid),
    .rec_take_i  (rec_take),
    .rec_o       (rec)
  );

  rsgt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_take_o  (rec_take),
    .rec_i       (rec),
    .out_if      (out_if)
  );

endmodule

>>> hdl/rsgt_track.sv
// Tracking stage: input register, configuration registers, sequence state
// and the combinational gap evaluation. Depends on rsgt_pkg and rsgt_in_if.
module rsgt_track (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [rsgt_pkg::DataW-1:0] cfg_wdata_i,
  rsgt_in_if.sink                  in_if,
  output logic                     rec_valid_o,
  input  logic                     rec_take_i,
  output rsgt_pkg::rec_t           rec_o
);
  import rsgt_pkg::*;

  logic [NodeW-1:0]  local_id_q;
  logic [SlotW-1:0]  conceal_q;

  logic              in_valid_q;
  logic              op_q;
  logic [NodeW-1:0]  sender_q;
  logic [SeqW-1:0]   seq_q;
  logic [SlotW-1:0]  free_q;

  logic              have_q, have_d;
  logic [SeqW-1:0]   last_seq_q, last_seq_d;
  logic [NodeW-1:0]  last_sender_q, last_sender_d;
  logic [CountW-1:0] packets_q, packets_d;
  logic [CountW-1:0] lost_q, lost_d;
  logic [CountW-1:0] dropped_q, dropped_d;

  logic              in_accept;
  logic              tracking;
  logic [SeqW-1:0]   gap;
  logic [SlotW-1:0]  limit;
  logic [SlotW-1:0]  room;
  logic [SlotW-1:0]  fit;
  logic [SlotW-1:0]  room_left;
  kind_e             kind;

  assign in_if.ready = !in_valid_q || rec_take_i;
  assign in_accept   = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= '0;
      conceal_q  <= SlotW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOCAL_NODE_ID: local_id_q <= cfg_wdata_i[NodeW-1:0];
        CFG_CONCEAL_LIMIT: conceal_q  <= cfg_wdata_i[SlotW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (rec_take_i) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= in_if.operation;
      sender_q <= in_if.sender_id;
      seq_q    <= in_if.sequence_req;
      free_q   <= in_if.queue_free;
    end
  end

  always_comb begin
    limit = (conceal_q > SlotW'(MaxPlaceholders)) ? SlotW'(MaxPlaceholders) : conceal_q;
    room  = (free_q > SlotW'(QueueDepth)) ? SlotW'(QueueDepth) : free_q;
    // A different sender than the one tracked starts a fresh sequence.
    tracking = have_q && (sender_q == last_sender_q);
    gap      = seq_q - last_seq_q - SeqW'(1);

    fit = '0;
    if (tracking && gap != '0 && gap <= SeqW'(limit)) begin
      fit = (gap[SlotW-1:0] < room) ? gap[SlotW-1:0] : room;
    end
    room_left = room - fit;

    have_d        = have_q;
    last_seq_d    = last_seq_q;
    last_sender_d = last_sender_q;
    packets_d     = packets_q;
    lost_d        = lost_q;
    dropped_d     = dropped_q;
    kind          = KIND_QUEUED;

    if (op_q == OP_RESTART) begin
      have_d = 1'b0;
      kind   = KIND_RESTART;
      fit    = '0;
    end else if (sender_q == local_id_q) begin
      kind = KIND_OWN;
      fit  = '0;
    end else if (tracking && gap == DupGap) begin
      dropped_d = dropped_q + CountW'(1);
      kind      = KIND_DUP;
      fit       = '0;
    end else begin
      if (tracking) begin
        lost_d = lost_q + CountW'(gap);
      end
      have_d        = 1'b1;
      last_seq_d    = seq_q;
      last_sender_d = sender_q;
      packets_d     = packets_q + CountW'(1);
      if (room_left != '0) begin
        kind = KIND_QUEUED;
      end else begin
        kind      = KIND_FULL;
        dropped_d = dropped_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q        <= 1'b0;
      last_seq_q    <= '0;
      last_sender_q <= '0;
      packets_q     <= '0;
      lost_q        <= '0;
      dropped_q     <= '0;
    end else if (rec_take_i) begin
      have_q        <= have_d;
      last_seq_q    <= last_seq_d;
      last_sender_q <= last_sender_d;
      packets_q     <= packets_d;
      lost_q        <= lost_d;
      dropped_q     <= dropped_d;
    end
  end

  assign rec_valid_o      = in_valid_q;
  assign rec_o.kind       = kind;
  assign rec_o.loss_cnt   = fit;
  assign rec_o.packets    = packets_d;
  assign rec_o.lost       = lost_d;
  assign rec_o.dropped    = dropped_d;

endmodule

>>> hdl/rsgt_emit.sv
// Result stage: holds one evaluated item and plays out its loss placeholders
// followed by the final result. Depends on rsgt_pkg and rsgt_out_if.
module rsgt_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rec_valid_i,
  output logic           rec_take_o,
  input  rsgt_pkg::rec_t rec_i,
  rsgt_out_if.source     out_if
);
  import rsgt_pkg::*;

  logic             res_valid_q;
  rec_t             rec_q;
  logic [SlotW-1:0] loss_left_q;
  logic             final_beat;
  logic             out_fire;

  assign final_beat = (loss_left_q == '0);
  assign out_fire   = res_valid_q && out_if.ready;
  // The register can reload in the same cycle its final result leaves.
  assign rec_take_o = rec_valid_i && (!res_valid_q || (out_fire && final_beat));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      loss_left_q <= '0;
    end else if (rec_take_o) begin
      res_valid_q <= 1'b1;
      loss_left_q <= rec_i.loss_cnt;
    end else if (out_fire) begin
      if (final_beat) begin
        res_valid_q <= 1'b0;
      end else begin
        loss_left_q <= loss_left_q - SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      rec_q <= rec_i;
    end
  end

  assign out_if.valid         = res_valid_q;
  assign out_if.kind          = final_beat ? 3'(rec_q.kind) : 3'(KIND_LOSS);
  assign out_if.last          = final_beat;
  assign out_if.packets_count = rec_q.packets;
  assign out_if.lost_count    = rec_q.lost;
  assign out_if.dropped_count = rec_q.dropped;

endmodule
